@@ design/mfps_pkg.sv @@
`default_nettype none

package mfps_pkg;

  // Fixed field widths of the ports.
  localparam int VAL_W     = 16;
  localparam int SUM_OUT_W = 21;
  localparam int COL_W     = 7;
  localparam int GS_W      = 7;

  localparam logic [GS_W-1:0] GS_RESET = 7'd8;

  // Largest value that the best_sum port can carry.
  localparam int SUM_OUT_MAX = 2097151;

  // Control flags that travel with a cell value down the chain.
  typedef struct packed {
    logic valid;
    logic done;       // the running sum has been computed
    logic first_row;  // the row above is all zeros
    logic first_col;  // no above-left neighbor
    logic has_right;  // an above-right neighbor exists
    logic last_row;
    logic last_cell;  // last cell of the grid, produces the result
  } mfps_flags_t;

endpackage

`default_nettype wire

@@ design/mfps_cell.sv @@
`default_nettype none

module mfps_cell
  import mfps_pkg::*;
#(
  parameter int SUM_W = 22,
  parameter int HOP_W = 6,
  parameter bit FWD_PREV = 1'b0
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      en_i,
  input  wire                      clr_i,
  input  wire  mfps_flags_t        flags_i,
  input  wire  signed [VAL_W-1:0]  value_i,
  input  wire         [HOP_W-1:0]  hops_i,
  input  wire  signed [SUM_W-1:0]  sum_i,
  input  wire  signed [SUM_W-1:0]  left_old_i,
  input  wire  signed [SUM_W-1:0]  right_prev_i,
  output mfps_flags_t              flags_o,
  output logic signed [VAL_W-1:0]  value_o,
  output logic        [HOP_W-1:0]  hops_o,
  output logic signed [SUM_W-1:0]  sum_o,
  output logic signed [SUM_W-1:0]  prev_o,
  output logic signed [SUM_W-1:0]  old_o
);

  mfps_flags_t              flags_q;
  logic signed [VAL_W-1:0]  value_q;
  logic        [HOP_W-1:0]  hops_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  prev_q;
  logic signed [SUM_W-1:0]  old_q;

  logic                     hit;
  logic signed [SUM_W-1:0]  above;
  logic signed [SUM_W-1:0]  left;
  logic signed [SUM_W-1:0]  right;
  logic signed [SUM_W-1:0]  best3;
  logic signed [SUM_W-1:0]  sum_d;

  // The item computes here once its hop count has run down to zero.
  assign hit = flags_q.valid && !flags_q.done && (hops_q == '0);

  always_comb begin
    above = flags_q.first_row ? '0 : prev_q;
    left  = (flags_q.first_row || flags_q.first_col) ? '0 : left_old_i;
    right = (flags_q.first_row || !flags_q.has_right) ? '0 : right_prev_i;
    best3 = above;
    if (left > best3) begin
      best3 = left;
    end
    if (right > best3) begin
      best3 = right;
    end
    sum_d = SUM_W'(value_q) + best3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (clr_i) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_i;
      hops_q  <= hops_i;
      sum_q   <= sum_i;
    end
  end

  // The old sum stays behind for the next column's above-left neighbor.
  always_ff @(posedge clk_i) begin
    if (en_i && hit && !clr_i) begin
      prev_q <= sum_d;
      old_q  <= prev_q;
    end
  end

  always_comb begin
    flags_o      = flags_q;
    flags_o.done = flags_q.done | hit;
  end

  assign value_o = value_q;
  assign hops_o  = (hops_q == '0) ? '0 : hops_q - 1'b1;
  assign sum_o   = hit ? sum_d : sum_q;
  // In a grid of side two the second column of the row above is still being
  // computed here while the first column of the next row needs it.
  assign prev_o  = (FWD_PREV && hit) ? sum_d : prev_q;
  assign old_o   = old_q;

endmodule

`default_nettype wire

@@ design/mfps_collect.sv @@
`default_nettype none

module mfps_collect
  import mfps_pkg::*;
#(
  parameter int SUM_W = 22
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        en_i,
  input  wire                        clr_i,
  input  wire  mfps_flags_t          flags_i,
  input  wire  signed [SUM_W-1:0]    sum_i,
  input  wire                        out_stall_i,
  output logic                       hold_o,
  output logic                       out_valid_o,
  output logic [SUM_OUT_W-1:0]       best_sum_o,
  output logic [COL_W-1:0]           best_column_o
);

  logic signed [SUM_W-1:0]  best_q;
  logic        [COL_W-1:0]  idx_q;
  logic        [COL_W-1:0]  cnt_q;
  logic                     out_valid_q;
  logic [SUM_OUT_W-1:0]     best_sum_q;
  logic [COL_W-1:0]         best_col_q;

  logic        [COL_W-1:0]  col1;
  logic                     upd;
  logic signed [SUM_W-1:0]  best_n;
  logic        [COL_W-1:0]  idx_n;
  logic signed [31:0]       best_ext;
  logic [SUM_OUT_W-1:0]     best_sat;
  logic                     take;

  // Items reach this point in column order, so a counter gives the column.
  assign col1   = cnt_q + 7'd1;
  assign upd    = flags_i.last_row && (sum_i > best_q);
  assign best_n = upd ? sum_i : best_q;
  assign idx_n  = upd ? col1 : idx_q;

  always_comb begin
    best_ext = 32'(best_n);
    if (best_ext > SUM_OUT_MAX) begin
      best_sat = '1;
    end else begin
      best_sat = best_ext[SUM_OUT_W-1:0];
    end
  end

  // A finished grid cannot leave the chain while the output register holds a stalled result.
  assign hold_o = out_valid_q && out_stall_i && flags_i.valid && flags_i.last_cell;
  assign take   = en_i && flags_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      idx_q  <= '0;
      cnt_q  <= '0;
    end else if (clr_i) begin
      best_q <= '0;
      idx_q  <= '0;
      cnt_q  <= '0;
    end else if (take) begin
      cnt_q <= flags_i.has_right ? col1 : '0;
      if (flags_i.last_cell) begin
        best_q <= '0;
        idx_q  <= '0;
      end else begin
        best_q <= best_n;
        idx_q  <= idx_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && flags_i.last_cell) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && flags_i.last_cell) begin
      best_sum_q <= best_sat;
      best_col_q <= idx_n;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign best_sum_o    = best_sum_q;
  assign best_column_o = best_col_q;

endmodule

`default_nettype wire

@@ design/max_falling_path_sum.sv @@
// Cells are taken at one per cycle while the input is not stalled.
// The result is registered after the last cell has run down the chain of
// MAX_SIZE column cells and through the collector.
// Reset sets the grid size to 8 and empties the chain; no clearing pass runs.
// A write of the grid size empties the chain and starts a new grid.
`default_nettype none

module max_falling_path_sum
  import mfps_pkg::*;
#(
  parameter int MAX_SIZE = 64
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire  [GS_W-1:0]        cfg_wdata_i,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire  signed [VAL_W-1:0] cell_value_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [SUM_OUT_W-1:0]   best_sum_o,
  output logic [COL_W-1:0]       best_column_o
);

  localparam int NW    = $clog2(MAX_SIZE + 1);
  localparam int HOP_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int SUM_W = VAL_W + $clog2(MAX_SIZE);

  logic [GS_W-1:0]  grid_size_q;
  logic [NW-1:0]    col_cnt_q;
  logic [NW-1:0]    row_cnt_q;
  logic [NW-1:0]    side_w;
  logic [NW:0]      col_nxt;
  logic [NW:0]      row_nxt;
  logic             has_right;
  logic             last_row;
  logic             en;
  logic             hold;
  logic             accept;

  mfps_flags_t              flags_w [MAX_SIZE+1];
  logic signed [VAL_W-1:0]  value_w [MAX_SIZE+1];
  logic        [HOP_W-1:0]  hops_w  [MAX_SIZE+1];
  logic signed [SUM_W-1:0]  sum_w   [MAX_SIZE+1];
  logic signed [SUM_W-1:0]  prev_w  [MAX_SIZE];
  logic signed [SUM_W-1:0]  old_w   [MAX_SIZE];

  always_comb begin
    if (grid_size_q == '0) begin
      side_w = NW'(1);
    end else if (32'(grid_size_q) > MAX_SIZE) begin
      side_w = NW'(MAX_SIZE);
    end else begin
      side_w = NW'(grid_size_q);
    end
  end

  assign col_nxt   = (NW+1)'(col_cnt_q) + 1'b1;
  assign row_nxt   = (NW+1)'(row_cnt_q) + 1'b1;
  assign has_right = col_nxt < (NW+1)'(side_w);
  assign last_row  = row_nxt == (NW+1)'(side_w);

  assign en         = !hold;
  assign in_stall_o = hold;
  assign accept     = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GS_RESET;
    end else if (cfg_we_i) begin
      grid_size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (cfg_we_i) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (accept) begin
      if (has_right) begin
        col_cnt_q <= col_nxt[NW-1:0];
      end else begin
        col_cnt_q <= '0;
        row_cnt_q <= last_row ? '0 : row_nxt[NW-1:0];
      end
    end
  end

  always_comb begin
    flags_w[0]           = '0;
    flags_w[0].valid     = in_valid_i;
    flags_w[0].first_row = (row_cnt_q == '0);
    flags_w[0].first_col = (col_cnt_q == '0);
    flags_w[0].has_right = has_right;
    flags_w[0].last_row  = last_row;
    flags_w[0].last_cell = last_row && !has_right;
  end

  assign value_w[0] = cell_value_i;
  assign hops_w[0]  = HOP_W'(col_cnt_q);
  assign sum_w[0]   = '0;

  for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
    logic signed [SUM_W-1:0] left_old;
    logic signed [SUM_W-1:0] right_prev;

    if (k == 0) begin : g_first
      assign left_old = '0;
    end else begin : g_inner_l
      assign left_old = old_w[k-1];
    end

    if (k == MAX_SIZE - 1) begin : g_last
      assign right_prev = '0;
    end else begin : g_inner_r
      assign right_prev = prev_w[k+1];
    end

    mfps_cell #(
      .SUM_W    (SUM_W),
      .HOP_W    (HOP_W),
      .FWD_PREV (k == 1)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (en),
      .clr_i        (cfg_we_i),
      .flags_i      (flags_w[k]),
      .value_i      (value_w[k]),
      .hops_i       (hops_w[k]),
      .sum_i        (sum_w[k]),
      .left_old_i   (left_old),
      .right_prev_i (right_prev),
      .flags_o      (flags_w[k+1]),
      .value_o      (value_w[k+1]),
      .hops_o       (hops_w[k+1]),
      .sum_o        (sum_w[k+1]),
      .prev_o       (prev_w[k]),
      .old_o        (old_w[k])
    );
  end

  mfps_collect #(
    .SUM_W (SUM_W)
  ) u_collect (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .clr_i         (cfg_we_i),
    .flags_i       (flags_w[MAX_SIZE]),
    .sum_i         (sum_w[MAX_SIZE]),
    .out_stall_i   (out_stall_i),
    .hold_o        (hold),
    .out_valid_o   (out_valid_o),
    .best_sum_o    (best_sum_o),
    .best_column_o (best_column_o)
  );

  // The input side only stalls behind a result that is waiting for transfer.
  a_stall_needs_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o
  ) else $error("input stalled without a pending result");

  // A column is named exactly when its sum beats the virtual zero column.
  a_zero_column: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((best_column_o == '0) == (best_sum_o == '0))
  ) else $error("best column and best sum disagree about the zero column");

  a_counters_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (col_cnt_q < side_w) && (row_cnt_q < side_w)
  ) else $error("grid position outside the grid");

endmodule

`default_nettype wire
